/* rtl/tphfm_pkg.sv */
// ----------------------------------------------------------------------------
// Timed peak-hold force meter package
// Shared word types, configuration record, codes and constants.
// ----------------------------------------------------------------------------
package tphfm_pkg;

	// Input word: one event of the stream.
	typedef struct packed {
		logic [1:0]         mode;
		logic signed [23:0] raw_sample;
		logic               button_level;
		logic [7:0]         command_byte;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] force_value;
	} out_word_t;

	// Configuration registers as seen by the engine.
	typedef struct packed {
		logic [15:0] gain;
		logic [15:0] dead_zone;
		logic [15:0] session_ms;
		logic [15:0] live_interval_ms;
		logic [15:0] peak_show_ms;
		logic        idle_level;
	} cfg_t;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CNT_W      = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Event codes.
	localparam logic [1:0] MODE_TICK    = 2'd0;
	localparam logic [1:0] MODE_SAMPLE  = 2'd1;
	localparam logic [1:0] MODE_BUTTON  = 2'd2;
	localparam logic [1:0] MODE_COMMAND = 2'd3;

	// Result codes.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_LIVE  = 2'd1;
	localparam logic [1:0] KIND_PEAK  = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	localparam logic [7:0] START_CMD = 8'h31;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SESSION_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIVE_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_SHOW_MS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL    = 3'd5;

	// Register reset values.
	localparam logic [15:0] GAIN_RST          = 16'd655;
	localparam logic [15:0] DEAD_ZONE_RST     = 16'd20;
	localparam logic [15:0] SESSION_MS_RST    = 16'd5000;
	localparam logic [15:0] LIVE_INTERVAL_RST = 16'd100;
	localparam logic [15:0] PEAK_SHOW_MS_RST  = 16'd10000;
	localparam logic        IDLE_LEVEL_RST    = 1'b0;

	// Counter increment that sticks at the top value.
	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage

/* rtl/tphfm_engine.sv */
// ----------------------------------------------------------------------------
// Timed peak-hold force meter engine
// Session state and the per-event update, one event per step.
// ----------------------------------------------------------------------------
module tphfm_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  tphfm_pkg::in_word_t  item,
	input  tphfm_pkg::cfg_t      cfg,
	output logic                 res_valid,
	output tphfm_pkg::out_word_t res
);

	logic                          measuring_q, measuring_d;
	logic                          showing_q, showing_d;
	logic                          taken_q, taken_d;
	logic                          prev_btn_q, prev_btn_d;
	logic signed [23:0]            offset_q, offset_d;
	logic [23:0]                   peak_q, peak_d;
	logic [tphfm_pkg::CNT_W-1:0]   sess_q, sess_d;
	logic [tphfm_pkg::CNT_W-1:0]   live_q, live_d;
	logic [tphfm_pkg::CNT_W-1:0]   show_q, show_d;

	logic signed [24:0] delta;
	logic [23:0]        diff;
	logic [39:0]        prod;
	logic [23:0]        force_raw;
	logic [23:0]        force_dz;
	logic               btn_edge;
	logic               start;

	// Force path: absolute difference, Q16 gain, dead zone.
	assign delta     = 25'(item.raw_sample) - 25'(offset_q);
	assign diff      = delta[24] ? 24'(-delta) : delta[23:0];
	assign prod      = {16'd0, diff} * {24'd0, cfg.gain};
	assign force_raw = prod[39:16];
	assign force_dz  = (force_raw < {8'd0, cfg.dead_zone}) ? 24'd0 : force_raw;

	assign btn_edge = (item.button_level != cfg.idle_level) && (prev_btn_q == cfg.idle_level);

	always_comb begin
		measuring_d = measuring_q;
		showing_d   = showing_q;
		taken_d     = taken_q;
		prev_btn_d  = prev_btn_q;
		offset_d    = offset_q;
		peak_d      = peak_q;
		sess_d      = sess_q;
		live_d      = live_q;
		show_d      = show_q;
		res_valid   = 1'b0;
		res         = '0;
		start       = 1'b0;

		unique case (item.mode)
			tphfm_pkg::MODE_TICK: begin
				if (measuring_q) begin
					sess_d = tphfm_pkg::inc_sat(sess_q);
					live_d = tphfm_pkg::inc_sat(live_q);
					if (sess_d > {1'b0, cfg.session_ms}) begin
						measuring_d     = 1'b0;
						showing_d       = 1'b1;
						show_d          = '0;
						res_valid       = 1'b1;
						res.kind        = tphfm_pkg::KIND_PEAK;
						res.force_value = peak_q;
					end
				end else if (showing_q) begin
					show_d = tphfm_pkg::inc_sat(show_q);
					if (show_d > {1'b0, cfg.peak_show_ms}) begin
						showing_d = 1'b0;
						res_valid = 1'b1;
						res.kind  = tphfm_pkg::KIND_END;
					end
				end
			end
			tphfm_pkg::MODE_SAMPLE: begin
				if (measuring_q) begin
					if (!taken_q) begin
						offset_d = item.raw_sample;
						taken_d  = 1'b1;
					end else begin
						if (force_dz > peak_q) begin
							peak_d = force_dz;
						end
						if (live_q >= {1'b0, cfg.live_interval_ms}) begin
							live_d          = '0;
							res_valid       = 1'b1;
							res.kind        = tphfm_pkg::KIND_LIVE;
							res.force_value = force_dz;
						end
					end
				end
			end
			tphfm_pkg::MODE_BUTTON: begin
				prev_btn_d = item.button_level;
				start      = btn_edge && !measuring_q;
			end
			tphfm_pkg::MODE_COMMAND: begin
				start = (item.command_byte == tphfm_pkg::START_CMD) && !measuring_q;
			end
			default: begin
			end
		endcase

		if (start) begin
			measuring_d = 1'b1;
			taken_d     = 1'b0;
			peak_d      = '0;
			sess_d      = '0;
			live_d      = '0;
			showing_d   = 1'b0;
			res_valid   = 1'b1;
			res.kind    = tphfm_pkg::KIND_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measuring_q <= 1'b0;
			showing_q   <= 1'b0;
			taken_q     <= 1'b0;
			prev_btn_q  <= tphfm_pkg::IDLE_LEVEL_RST;
			offset_q    <= '0;
			peak_q      <= '0;
			sess_q      <= '0;
			live_q      <= '0;
			show_q      <= '0;
		end else if (step) begin
			measuring_q <= measuring_d;
			showing_q   <= showing_d;
			taken_q     <= taken_d;
			prev_btn_q  <= prev_btn_d;
			offset_q    <= offset_d;
			peak_q      <= peak_d;
			sess_q      <= sess_d;
			live_q      <= live_d;
			show_q      <= show_d;
		end
	end

endmodule

/* rtl/timed_peak_hold_force_meter_core.sv */
// ----------------------------------------------------------------------------
// Timed peak-hold force meter core
// Session control, tare, peak hold and timed reporting for a load cell.
// ----------------------------------------------------------------------------
// Usage notes.
// Events arrive on the input channel (in_valid, in_stall, in_word): ticks,
// load-cell samples, button levels and command bytes. Each event yields zero
// or one result word on the output channel (out_valid, out_stall, out_word).
// A word moves on either channel at a rising edge with valid high and stall
// low.
// An accepted event is held in the input stage register, then the engine
// updates the session state and writes any result into the output
// register. One event can be accepted every cycle while in_stall is low;
// the throughput is set by the combinational state update (one 24 by 16
// multiply plus compares).
// When the receiver stalls with a result waiting, the input stage still takes
// one more word; in_stall then rises until the output word is taken.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// do so while the block is idle, which the block does not enforce. Unused indexes
// are ignored. Reset clears both stages, ends any session, loads register defaults.
// ----------------------------------------------------------------------------
module timed_peak_hold_force_meter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  tphfm_pkg::in_word_t                  in_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output tphfm_pkg::out_word_t                 out_word,
	input  logic                                 cfg_we,
	input  logic [tphfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tphfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tphfm_pkg::cfg_t      cfg_q;
	tphfm_pkg::in_word_t  item_s1;
	logic                 valid_s1;
	logic                 advance;
	logic                 step;
	logic                 accept;
	logic                 res_valid;
	tphfm_pkg::out_word_t res;
	logic                 out_valid_q;
	tphfm_pkg::out_word_t out_word_q;

	// The input stage moves on whenever the output register is free or
	// is being emptied in this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain             <= tphfm_pkg::GAIN_RST;
			cfg_q.dead_zone        <= tphfm_pkg::DEAD_ZONE_RST;
			cfg_q.session_ms       <= tphfm_pkg::SESSION_MS_RST;
			cfg_q.live_interval_ms <= tphfm_pkg::LIVE_INTERVAL_RST;
			cfg_q.peak_show_ms     <= tphfm_pkg::PEAK_SHOW_MS_RST;
			cfg_q.idle_level       <= tphfm_pkg::IDLE_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tphfm_pkg::REG_GAIN:          cfg_q.gain             <= cfg_data;
				tphfm_pkg::REG_DEAD_ZONE:     cfg_q.dead_zone        <= cfg_data;
				tphfm_pkg::REG_SESSION_MS:    cfg_q.session_ms       <= cfg_data;
				tphfm_pkg::REG_LIVE_INTERVAL: cfg_q.live_interval_ms <= cfg_data;
				tphfm_pkg::REG_PEAK_SHOW_MS:  cfg_q.peak_show_ms     <= cfg_data;
				tphfm_pkg::REG_IDLE_LEVEL:    cfg_q.idle_level       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Input stage: valid bit under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_word;
		end
	end

	// The engine holds all session state and updates it once per event.
	tphfm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: loaded whenever the input stage advances; an event
	// without a result leaves it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

/* rtl/tphfm_checker.sv */
// ----------------------------------------------------------------------------
// Timed peak-hold force meter checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module tphfm_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input tphfm_pkg::out_word_t out_word
);

	// A waiting result stays and keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// Session start and display end carry no force.
	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.kind == tphfm_pkg::KIND_START ||
		out_word.kind == tphfm_pkg::KIND_END) |-> out_word.force_value == 24'd0)
		else $error("force on a start or end word");

	// The input side only stalls behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// A new result follows an accepted event, held in the input stage first.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted event");

endmodule

bind timed_peak_hold_force_meter_core tphfm_checker u_tphfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

/* tb/tphfm_checker.sv */
// ----------------------------------------------------------------------------
// Force meter stream checker
// Watches both channels and the register port of the force meter core. It
// keeps its own copy of the session state, works out the result word of
// each accepted event and compares every result word that leaves the block
// with the oldest one still awaited.
// ----------------------------------------------------------------------------
module tphfm_stream_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  tphfm_pkg::in_word_t                in_word,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  tphfm_pkg::out_word_t               out_word,
	input  logic                               cfg_we,
	input  logic [tphfm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tphfm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                 errors,
	output int                                 outstanding,
	output int                                 compared
);

	import tphfm_pkg::*;

	cfg_t                   settings;
	logic                   in_session;
	logic                   showing_peak;
	logic                   tare_done;
	logic                   button_prev;
	logic signed [23:0]     tare;
	logic [23:0]            peak_hold;
	logic [CNT_W-1:0]       session_ticks;
	logic [CNT_W-1:0]       live_ticks;
	logic [CNT_W-1:0]       show_ticks;
	out_word_t              awaited_words[$];

	task automatic report(input string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + CNT_W'(1);
	endfunction

	function automatic bit open_session(output out_word_t r);
		in_session    = 1'b1;
		tare_done     = 1'b0;
		peak_hold     = '0;
		session_ticks = '0;
		live_ticks    = '0;
		showing_peak  = 1'b0;
		r.kind        = KIND_START;
		r.force_value = '0;
		return 1'b1;
	endfunction

	// Applies one event to the session state; returns 1 when it yields a word.
	function automatic bit meter_result(input in_word_t w, output out_word_t r);
		logic [24:0] delta;
		logic [24:0] magnitude;
		logic [40:0] scaled;
		logic [23:0] force_now;
		bit          pressed;
		r = '0;
		case (w.mode)
			MODE_TICK: begin
				if (in_session) begin
					session_ticks = count_up(session_ticks);
					live_ticks    = count_up(live_ticks);
					if (session_ticks > {1'b0, settings.session_ms}) begin
						in_session    = 1'b0;
						showing_peak  = 1'b1;
						show_ticks    = '0;
						r.kind        = KIND_PEAK;
						r.force_value = peak_hold;
						return 1'b1;
					end
				end else if (showing_peak) begin
					show_ticks = count_up(show_ticks);
					if (show_ticks > {1'b0, settings.peak_show_ms}) begin
						showing_peak = 1'b0;
						r.kind       = KIND_END;
						return 1'b1;
					end
				end
				return 1'b0;
			end
			MODE_SAMPLE: begin
				if (!in_session)
					return 1'b0;
				if (!tare_done) begin
					tare      = w.raw_sample;
					tare_done = 1'b1;
					return 1'b0;
				end
				delta     = {w.raw_sample[23], w.raw_sample} - {tare[23], tare};
				magnitude = delta[24] ? (~delta + 25'd1) : delta;
				scaled    = {16'd0, magnitude} * {25'd0, settings.gain};
				force_now = scaled[39:16];
				if (force_now < {8'd0, settings.dead_zone})
					force_now = '0;
				if (force_now > peak_hold)
					peak_hold = force_now;
				if (live_ticks >= {1'b0, settings.live_interval_ms}) begin
					live_ticks    = '0;
					r.kind        = KIND_LIVE;
					r.force_value = force_now;
					return 1'b1;
				end
				return 1'b0;
			end
			MODE_BUTTON: begin
				pressed = (w.button_level != settings.idle_level) &&
				          (button_prev == settings.idle_level);
				button_prev = w.button_level;
				if (pressed && !in_session)
					return open_session(r);
				return 1'b0;
			end
			default: begin
				if (w.command_byte == START_CMD && !in_session)
					return open_session(r);
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t made;
		if (!arst_n) begin
			settings.gain             = GAIN_RST;
			settings.dead_zone        = DEAD_ZONE_RST;
			settings.session_ms       = SESSION_MS_RST;
			settings.live_interval_ms = LIVE_INTERVAL_RST;
			settings.peak_show_ms     = PEAK_SHOW_MS_RST;
			settings.idle_level       = IDLE_LEVEL_RST;
			in_session    = 1'b0;
			showing_peak  = 1'b0;
			tare_done     = 1'b0;
			tare          = '0;
			peak_hold     = '0;
			session_ticks = '0;
			live_ticks    = '0;
			show_ticks    = '0;
			button_prev   = IDLE_LEVEL_RST;
			awaited_words.delete();
			errors      = 0;
			compared    = 0;
			outstanding = 0;
		end else begin
			// Results trail their events through the input stage and the output
			// register, so the output is checked before this edge's input word is predicted.
			if (out_valid && !out_stall) begin
				if (awaited_words.size() == 0) begin
					report($sformatf("unexpected result word kind %0d force %0d",
					                 out_word.kind, out_word.force_value));
				end else begin
					want = awaited_words.pop_front();
					compared++;
					if (out_word.kind !== want.kind)
						report($sformatf("kind %0d, expected %0d",
						                 out_word.kind, want.kind));
					if (out_word.force_value !== want.force_value)
						report($sformatf("force %0d, expected %0d (kind %0d)",
						                 out_word.force_value, want.force_value,
						                 want.kind));
				end
			end
			if (in_valid && !in_stall) begin
				if (meter_result(in_word, made))
					awaited_words.push_back(made);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GAIN:          settings.gain             = cfg_data;
					REG_DEAD_ZONE:     settings.dead_zone        = cfg_data;
					REG_SESSION_MS:    settings.session_ms       = cfg_data;
					REG_LIVE_INTERVAL: settings.live_interval_ms = cfg_data;
					REG_PEAK_SHOW_MS:  settings.peak_show_ms     = cfg_data;
					REG_IDLE_LEVEL:    settings.idle_level       = cfg_data[0];
					default: ;
				endcase
			end
			outstanding = awaited_words.size();
		end
	end

endmodule

/* tb/tb_timed_peak_hold_force_meter_core.sv */
// ----------------------------------------------------------------------------
// Force meter core testbench
// Drives events into the force meter core with random gaps and random
// output stalls, changes the registers between phases, and leaves all
// result checking to the stream checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_timed_peak_hold_force_meter_core;

	import tphfm_pkg::*;

	// Indexes past the last register; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	// Work words (ticks and samples) to send before the run winds down.
	localparam int WORK_TARGET = 800;
	// Work words per register setting.
	localparam int PHASE_WORK  = 70;
	// Cycles to let pass after the last awaited word, enough to cover any
	// event still in flight through the core with no result.
	localparam int SETTLE      = 4;
	// Cycles to wait for awaited words before giving up.
	localparam int DRAIN_LIMIT = 50000;
	// Upper bound on ticks sent to run out one session or one peak display.
	localparam int TICK_CAP    = 200;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_word_t   in_word;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_word_t  out_word;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	int errors;
	int outstanding;
	int compared;

	// Stimulus side copy of the registers, so that sessions can be shaped
	// around the current window lengths and button polarity.
	cfg_t current;
	// While set, neither side idles.
	bit   calm;
	int   sent_words;
	int   work_words;
	int   settings_used;

	timed_peak_hold_force_meter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tphfm_stream_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding),
		.compared    (compared)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random, except in the calm stretch. Stalls
	// land on every phase of a session since they are drawn per cycle,
	// independent of what the core is doing.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 27);
	end

	// Hard stop in case the core hangs somewhere the drain loop cannot see.
	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Every field is filled with random bits, so bits that the chosen event
	// does not use still toggle and must be ignored by the core.
	function automatic in_word_t random_word(input logic [1:0] mode);
		in_word_t    w;
		logic [31:0] bits;
		bits           = $urandom;
		w.mode         = mode;
		w.raw_sample   = bits[23:0];
		w.button_level = bits[24];
		w.command_byte = 8'($urandom_range(0, 255));
		return w;
	endfunction

	// Sends one word. It is called at a rising edge and returns at the rising
	// edge where the word is taken, so that the next call can drive the next
	// word in the same step without lowering valid in between. The stall is
	// looked at on the falling edge, where it is settled.
	task automatic send_word(input in_word_t w);
		int gap;
		bit stalled;
		gap = 0;
		while (!calm && $urandom_range(0, 99) < 27)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		sent_words++;
		if (w.mode == MODE_TICK || w.mode == MODE_SAMPLE)
			work_words++;
	endtask

	task automatic send_event(input logic [1:0] mode, input logic signed [23:0] raw,
	                          input logic level, input logic [7:0] cmd);
		in_word_t w;
		w.mode         = mode;
		w.raw_sample   = raw;
		w.button_level = level;
		w.command_byte = cmd;
		send_word(w);
	endtask

	// Stops input and waits until every awaited word has come out, then gives
	// the core a few cycles more. Returns at a rising edge.
	task automatic drain(output bit done);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		done = (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all six registers on back-to-back cycles, then one index past
	// the end with junk. The idle level goes out with random upper bits,
	// which the core must drop.
	task automatic load_settings(input cfg_t c);
		logic [15:0] junk;
		junk = 16'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GAIN;
		cfg_data  <= c.gain;
		@(posedge clk);
		cfg_index <= REG_DEAD_ZONE;
		cfg_data  <= c.dead_zone;
		@(posedge clk);
		cfg_index <= REG_SESSION_MS;
		cfg_data  <= c.session_ms;
		@(posedge clk);
		cfg_index <= REG_LIVE_INTERVAL;
		cfg_data  <= c.live_interval_ms;
		@(posedge clk);
		cfg_index <= REG_PEAK_SHOW_MS;
		cfg_data  <= c.peak_show_ms;
		@(posedge clk);
		cfg_index <= REG_IDLE_LEVEL;
		cfg_data  <= {junk[15:1], c.idle_level};
		@(posedge clk);
		cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_we    <= 1'b0;
		current = c;
		settings_used++;
	endtask

	// Mostly short windows so that sessions end within a few dozen ticks,
	// with the register extremes mixed in.
	function automatic cfg_t random_settings();
		cfg_t c;
		int   roll;
		roll   = $urandom_range(0, 9);
		c.gain = (roll == 0) ? 16'd1 : (roll == 1) ? 16'hFFFF :
		         16'($urandom_range(1, 65535));
		roll   = $urandom_range(0, 19);
		c.dead_zone = (roll < 3) ? 16'd0 : (roll == 3) ? 16'hFFFF :
		              (roll < 12) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
		roll   = $urandom_range(0, 9);
		c.session_ms = (roll == 0) ? 16'd0 : 16'($urandom_range(1, 40));
		roll   = $urandom_range(0, 19);
		c.live_interval_ms = (roll < 2) ? 16'd0 : (roll == 2) ? 16'hFFFF :
		                     16'($urandom_range(1, 8));
		roll   = $urandom_range(0, 9);
		c.peak_show_ms = (roll == 0) ? 16'd0 : 16'($urandom_range(1, 40));
		c.idle_level   = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// A run of ticks with a little noise mixed in. Noise may be a sample
	// after the session, a stray command or a button change; the last two
	// may legally start a new session during the peak display.
	task automatic tick_run(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 8)
				send_word(random_word(2'($urandom_range(MODE_SAMPLE, MODE_COMMAND))));
			else
				send_word(random_word(MODE_TICK));
		end
	endtask

	// One well-formed session with random content: a start by button edge or
	// by command, the tare sample, a mix of samples and ticks, then enough
	// ticks to run out the window and the peak display. One session in ten
	// is left unfinished and runs into the next one.
	task automatic run_session();
		in_word_t          w;
		logic signed [23:0] tare;
		int                body;
		int                span;
		int                amount;
		int                roll;
		if ($urandom_range(0, 1)) begin
			w = random_word(MODE_BUTTON);
			w.button_level = current.idle_level;
			send_word(w);
			w = random_word(MODE_BUTTON);
			w.button_level = ~current.idle_level;
			send_word(w);
		end else begin
			w = random_word(MODE_COMMAND);
			w.command_byte = START_CMD;
			send_word(w);
		end
		w = random_word(MODE_SAMPLE);
		tare = w.raw_sample;
		send_word(w);
		// Small spans keep forces near the dead zone; the widest reaches the
		// full converter range.
		roll = $urandom_range(0, 2);
		span = (roll == 0) ? 200 : (roll == 1) ? 20000 : 8388607;
		body = $urandom_range(2, 24);
		for (int i = 0; i < body; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				w = random_word(MODE_SAMPLE);
				if ($urandom_range(0, 3) != 0) begin
					amount = $urandom_range(0, span);
					w.raw_sample = $urandom_range(0, 1) ? 24'(tare + amount) :
					               24'(tare - amount);
				end
				send_word(w);
			end else if (roll < 85) begin
				send_word(random_word(MODE_TICK));
			end else begin
				w = random_word(2'($urandom_range(MODE_BUTTON, MODE_COMMAND)));
				if ($urandom_range(0, 2) == 0)
					w.command_byte = START_CMD;
				send_word(w);
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			tick_run((current.session_ms < TICK_CAP) ? current.session_ms + 2 : TICK_CAP);
			tick_run((current.peak_show_ms < TICK_CAP) ? current.peak_show_ms + 2 : TICK_CAP);
		end
	endtask

	initial begin
		cfg_t  extreme;
		bit    done;
		int    phase;
		int    budget;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		calm      = 1'b0;
		sent_words    = 0;
		work_words    = 0;
		settings_used = 0;
		current.gain             = GAIN_RST;
		current.dead_zone        = DEAD_ZONE_RST;
		current.session_ms       = SESSION_MS_RST;
		current.live_interval_ms = LIVE_INTERVAL_RST;
		current.peak_show_ms     = PEAK_SHOW_MS_RST;
		current.idle_level       = IDLE_LEVEL_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset values. Samples, ticks and commands
		// other than the start code do nothing while idle. The button press
		// from the idle level starts a session; a second press and a start
		// command during the session are both ignored. The first sample is
		// the tare, then the converter extremes and a force inside the dead
		// zone. The live interval has not run out, so nothing is reported.
		send_event(MODE_SAMPLE,  24'sd123,     1'b0, 8'h00);
		send_event(MODE_TICK,    24'sd0,       1'b0, 8'h00);
		send_event(MODE_COMMAND, 24'sd0,       1'b0, 8'h00);
		send_event(MODE_COMMAND, 24'sd0,       1'b1, 8'hFF);
		send_event(MODE_BUTTON,  24'sd0,       1'b0, 8'h00);
		send_event(MODE_BUTTON,  24'sd0,       1'b1, 8'h00);
		send_event(MODE_BUTTON,  24'sd0,       1'b0, 8'h00);
		send_event(MODE_BUTTON,  24'sd0,       1'b1, 8'h00);
		send_event(MODE_COMMAND, 24'sd0,       1'b0, START_CMD);
		send_event(MODE_SAMPLE,  24'sd0,       1'b0, 8'h00);
		send_event(MODE_SAMPLE,  24'sd8388607, 1'b0, 8'h00);
		send_event(MODE_SAMPLE,  -24'sd8388608, 1'b0, 8'h00);
		send_event(MODE_SAMPLE,  24'sd10,      1'b0, 8'h00);
		send_event(MODE_TICK,    24'sd0,       1'b0, 8'h00);
		drain(done);

		// Zero-length windows, zero live interval, full gain, no dead zone
		// and an inverted button. The session still open from above ends on
		// the next tick and the peak display on the one after. With the idle
		// level now high, a low level starts the next session, since the
		// button was last seen high. Tare at the bottom of the range and a
		// sample at the top give the largest force the core can produce.
		extreme.gain             = 16'hFFFF;
		extreme.dead_zone        = 16'd0;
		extreme.session_ms       = 16'd0;
		extreme.live_interval_ms = 16'd0;
		extreme.peak_show_ms     = 16'd0;
		extreme.idle_level       = 1'b1;
		load_settings(extreme);
		send_event(MODE_TICK,    24'sd0,        1'b0, 8'h00);
		send_event(MODE_TICK,    24'sd0,        1'b0, 8'h00);
		send_event(MODE_BUTTON,  24'sd0,        1'b0, 8'h00);
		send_event(MODE_SAMPLE,  -24'sd8388608, 1'b0, 8'h00);
		send_event(MODE_SAMPLE,  24'sd8388607,  1'b0, 8'h00);
		send_event(MODE_SAMPLE,  -24'sd8388608, 1'b0, 8'h00);
		send_event(MODE_TICK,    24'sd0,        1'b0, 8'h00);
		send_event(MODE_TICK,    24'sd0,        1'b0, 8'h00);
		send_event(MODE_COMMAND, 24'sd0,        1'b0, START_CMD);
		send_event(MODE_SAMPLE,  24'sd0,        1'b0, 8'h00);
		send_event(MODE_TICK,    24'sd0,        1'b0, 8'h00);
		send_event(MODE_TICK,    24'sd0,        1'b0, 8'h00);
		drain(done);

		// Random part: one register setting per phase, sessions until the
		// phase has had its share of ticks and samples. Phase two sets the
		// windows and the dead zone to their top values and the gain to one,
		// so the session it opens never closes and its later starts are ignored
		// until a later phase shortens the window. Phase one never idles on either side.
		phase = 0;
		while (done && work_words < WORK_TARGET) begin
			if (phase == 2) begin
				extreme.gain             = 16'd1;
				extreme.dead_zone        = 16'hFFFF;
				extreme.session_ms       = 16'hFFFF;
				extreme.live_interval_ms = 16'hFFFF;
				extreme.peak_show_ms     = 16'hFFFF;
				extreme.idle_level       = 1'($urandom_range(0, 1));
				load_settings(extreme);
			end else begin
				load_settings(random_settings());
			end
			calm   = (phase == 1);
			budget = work_words + PHASE_WORK;
			while (work_words < budget)
				run_session();
			calm = 1'b0;
			drain(done);
			phase++;
		end

		@(negedge clk);
		$display("Summary: %0d words sent, %0d of them ticks or samples, under %0d settings.",
		         sent_words, work_words, settings_used);
		$display("Summary: %0d result words compared, %0d mismatches.", compared, errors);
		if (done && errors == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/tphfm_pkg.sv
rtl/tphfm_engine.sv
rtl/timed_peak_hold_force_meter_core.sv
rtl/tphfm_checker.sv
tb/tphfm_checker.sv
tb/tb_timed_peak_hold_force_meter_core.sv
